[design/asa_pkg.sv]
// Package for the aligned stack allocator: item types, operation codes,
// controller states and parameter defaults.
// No dependencies; the allocator top level imports it.
package asa_pkg;

  // Parameter defaults.
  localparam int DEPTH_DEF        = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 32;

  // Register reset values.
  localparam logic [31:0] REGION_BASE_RST     = 32'd0;
  localparam logic [31:0] REGION_CAPACITY_RST = 32'd65536;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_EXTEND = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  // Register select, taken from address bit 2.
  localparam logic REG_BASE     = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Input item.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] byte_count;
    logic [2:0]  align_log2;
  } asa_in_t;

  // Result item.
  typedef struct packed {
    logic [31:0] user_address;
    logic        overflow;
    logic        misuse;
    logic [6:0]  live_count;
  } asa_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_ALIGN,
    ST_DONE
  } asa_state_t;

endpackage

[design/aligned_stack_allocator.sv]
// Aligned stack allocator top level: controller, address datapath, entry memories
// and configuration registers. Depends on asa_pkg.
//
// Usage: an item is taken when start is high while busy is low. Each item yields
// exactly one result, shown on out_item for one cycle with out_strobe high once the
// finish state is done; the receiver cannot stall it. An item occupies the block
// through accept, sum, align and finish, and no new item is accepted until the
// block is idle again. The entry memories have a registered read; then come the
// header-address add (sum), the alignment round-up (align) and the end-of-allocation
// add and limit compare (finish). The entry memories need no clearing after reset:
// only entries below the live count are ever used. Region registers are written over
// the APB port; the user must write them only while the block is idle, as the block does not enforce it.
module aligned_stack_allocator #(
  parameter int DEPTH        = asa_pkg::DEPTH_DEF,
  parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = asa_pkg::ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // Command channel
  input  logic             start,
  output logic             busy,
  input  asa_pkg::asa_in_t in_item,
  // Result channel
  output logic             out_strobe,
  output asa_pkg::asa_out_t out_item,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import asa_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int SW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Configuration registers.
  logic [31:0] region_base_r;
  logic [31:0] region_capacity_r;

  // Control state.
  asa_state_t  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] top_hdr_r, top_hdr_nxt;
  logic        out_valid_r;

  // Payload registers.
  asa_in_t     item_r;
  logic [SW-1:0] wb_r, wb_nxt;
  logic [SW-1:0] limit_r, limit_nxt;
  logic [SW-1:0] user_r, user_nxt;
  asa_out_t    out_item_r, res_nxt;

  // Entry memories with registered read data.
  logic [AW-1:0] hdr_mem [DEPTH];
  logic [31:0]   size_mem [DEPTH];
  logic [AW-1:0] hdr_rd_r;
  logic [31:0]   size_rd_r;
  logic [IW-1:0] rd_size_idx, rd_hdr_idx;

  // Write-back controls.
  logic          hdr_we, size_we;
  logic [IW-1:0] hdr_wr_idx, size_wr_idx;
  logic [AW-1:0] hdr_wr_data;
  logic [31:0]   size_wr_data;

  // Address helpers.
  logic [AW-1:0] base_a, cap_a;
  logic [SW-1:0] base_ext, cap_ext, top_ext, mask_ext, limit_sum;
  logic [SW-1:0] align_m1, end_full;
  logic [7:0]    align_bytes;
  logic [32:0]   ext_sum;
  logic [AW-1:0] hdr_new;
  logic          cfg_wr;
  logic          is_empty, is_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register read data.
  always_comb begin
    prdata = region_base_r;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = region_capacity_r;
    end
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r     <= REGION_BASE_RST;
      region_capacity_r <= REGION_CAPACITY_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BASE) begin
        region_base_r <= pwdata;
      end else begin
        region_capacity_r <= pwdata;
      end
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;
  assign is_empty   = (count_r == '0);
  assign is_full    = (count_r == CW'(DEPTH));

  // The read targets the top entry for sizes and the one under it for headers, or entry 0 when the stack is shallower.
  always_comb begin
    rd_size_idx = '0;
    rd_hdr_idx  = '0;
    if (count_r >= CW'(1)) begin
      rd_size_idx = IW'(count_r - CW'(1));
    end
    if (count_r >= CW'(2)) begin
      rd_hdr_idx = IW'(count_r - CW'(2));
    end
  end

  // Header address memory.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_wr_idx] <= hdr_wr_data;
    end
    hdr_rd_r <= hdr_mem[rd_hdr_idx];
  end

  // Size memory.
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wr_idx] <= size_wr_data;
    end
    size_rd_r <= size_mem[rd_size_idx];
  end

  // Address values widened so that carries past the address space stay visible.
  assign base_a    = AW'(region_base_r);
  assign cap_a     = AW'(region_capacity_r);
  assign base_ext  = SW'(base_a);
  assign cap_ext   = SW'(cap_a);
  assign top_ext   = SW'(top_hdr_r);
  assign mask_ext  = SW'({AW{1'b1}});
  assign limit_sum = base_ext + cap_ext;

  // Sum stage: candidate header end and region limit, the limit clamped to the address space.
  always_comb begin
    if (is_empty) begin
      wb_nxt = base_ext + SW'(HEADER_BYTES);
    end else begin
      wb_nxt = top_ext + SW'(2 * HEADER_BYTES) + SW'(size_rd_r);
    end
    limit_nxt = (limit_sum > mask_ext) ? mask_ext : limit_sum;
  end

  // Align stage: round the user address up to the requested power of two.
  assign align_bytes = 8'd1 << item_r.align_log2;
  assign align_m1    = SW'(align_bytes - 8'd1);
  assign user_nxt    = (wb_r + align_m1) & ~align_m1;

  // Finish stage arithmetic. Any carry past the address space also exceeds the limit.
  assign end_full = user_r + SW'(item_r.byte_count);
  assign hdr_new  = AW'(user_r - SW'(HEADER_BYTES));
  assign ext_sum  = {1'b0, size_rd_r} + {1'b0, item_r.byte_count};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM:   state_nxt = ST_ALIGN;
      ST_ALIGN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Finish-stage decisions: stack update, memory write-back and the result.
  always_comb begin
    count_nxt    = count_r;
    top_hdr_nxt  = top_hdr_r;
    hdr_we       = 1'b0;
    size_we      = 1'b0;
    hdr_wr_idx   = IW'(count_r);
    size_wr_idx  = IW'(count_r);
    hdr_wr_data  = hdr_new;
    size_wr_data = item_r.byte_count;
    res_nxt      = '0;
    if (state_r == ST_DONE) begin
      unique case (item_r.mode)
        MODE_ALLOC: begin
          if (is_full) begin
            res_nxt.misuse = 1'b1;
          end else if (end_full > limit_r) begin
            res_nxt.overflow = 1'b1;
          end else begin
            hdr_we                = 1'b1;
            size_we               = 1'b1;
            top_hdr_nxt           = hdr_new;
            count_nxt             = count_r + CW'(1);
            res_nxt.user_address  = user_r[31:0];
          end
        end
        MODE_EXTEND: begin
          if (is_empty) begin
            res_nxt.misuse = 1'b1;
          end else begin
            size_we      = 1'b1;
            size_wr_idx  = rd_size_idx;
            size_wr_data = ext_sum[32] ? 32'hFFFF_FFFF : ext_sum[31:0];
          end
        end
        MODE_POP: begin
          if (is_empty) begin
            res_nxt.misuse = 1'b1;
          end else begin
            count_nxt   = count_r - CW'(1);
            top_hdr_nxt = (count_r == CW'(1)) ? base_a : hdr_rd_r;
          end
        end
        default: begin
        end
      endcase
      res_nxt.live_count = 7'(count_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      top_hdr_r   <= AW'(REGION_BASE_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_hdr_r   <= top_hdr_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      item_r <= in_item;
    end
    if (state_r == ST_SUM) begin
      wb_r    <= wb_nxt;
      limit_r <= limit_nxt;
    end
    if (state_r == ST_ALIGN) begin
      user_r <= user_nxt;
    end
    if (state_r == ST_DONE) begin
      out_item_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result follows only the finish stage.
  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_DONE))
    else $error("result strobe without a finished item");

  // An accepted item enters the sum stage.
  a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_SUM))
    else $error("accepted item did not start");

  // The live count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("live count beyond depth");

  // A rejected or ignored request reports no address and leaves the count alone.
  a_flag_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.overflow || out_item.misuse)) |->
      (out_item.user_address == 32'd0) && $stable(count_r))
    else $error("flagged request changed state or returned an address");

  // The count moves only in the finish stage.
  a_count_moves_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DONE) |=> $stable(count_r))
    else $error("live count changed outside the finish stage");
`endif

endmodule
